[rtl/sfrc_pkg.sv]
// Shared constants, types and the CRC-16/MODBUS byte update for the frame receiver.
package sfrc_pkg;

    localparam int BUF_DEPTH = 256;
    localparam int BUF_AW    = $clog2(BUF_DEPTH);
    localparam int CNT_W     = $clog2(BUF_DEPTH + 1);
    localparam int CMP_W     = (CNT_W > 8) ? CNT_W : 9;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic [7:0] START_RESET  = 8'hFE;
    localparam logic [7:0] ESCAPE_RESET = 8'hFD;
    localparam logic [7:0] FINISH_RESET = 8'hA5;

    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    localparam logic [1:0] REG_START  = 2'd0;
    localparam logic [1:0] REG_ESCAPE = 2'd1;
    localparam logic [1:0] REG_FINISH = 2'd2;

    localparam logic REQ_RX   = 1'b0;
    localparam logic REQ_READ = 1'b1;

    localparam int OQ_DEPTH = 3;

    typedef enum logic [2:0] {
        MODE_IDLE = 3'b001,
        MODE_CMD  = 3'b010,
        MODE_DATA = 3'b100
    } sfrc_mode_t;

    typedef struct packed {
        logic [7:0] start_byte;
        logic [7:0] escape_byte;
        logic [7:0] finish_byte;
    } sfrc_cfg_t;

    typedef struct packed {
        logic       frame_ended;
        logic       frame_ok;
        logic [7:0] cmd_value;
        logic [7:0] payload_count;
        logic [7:0] read_data;
    } sfrc_rslt_t;

    function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

[rtl/sfrc_cfg.sv]
// Configuration register file holding the three delimiter bytes behind the APB port.
module sfrc_cfg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [sfrc_pkg::APB_AW-1:0] paddr,
    input  logic [sfrc_pkg::APB_DW-1:0] pwdata,
    output logic [sfrc_pkg::APB_DW-1:0] prdata,
    output logic                        pready,
    output sfrc_pkg::sfrc_cfg_t         cfg
);
    import sfrc_pkg::*;

    sfrc_cfg_t   cfg_reg;
    logic [1:0]  reg_idx;
    logic        wr_en;

    assign reg_idx = paddr[3:2];
    assign wr_en   = psel & penable & pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_byte  <= START_RESET;
            cfg_reg.escape_byte <= ESCAPE_RESET;
            cfg_reg.finish_byte <= FINISH_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_START:  cfg_reg.start_byte  <= pwdata[7:0];
                REG_ESCAPE: cfg_reg.escape_byte <= pwdata[7:0];
                REG_FINISH: cfg_reg.finish_byte <= pwdata[7:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_START:  prdata = {{(APB_DW-8){1'b0}}, cfg_reg.start_byte};
            REG_ESCAPE: prdata = {{(APB_DW-8){1'b0}}, cfg_reg.escape_byte};
            REG_FINISH: prdata = {{(APB_DW-8){1'b0}}, cfg_reg.finish_byte};
            default:    prdata = '0;
        endcase
    end

endmodule

[rtl/sfrc_core.sv]
// Framing receiver, payload buffer and running CRC, ending in the result register.
module sfrc_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  sfrc_pkg::sfrc_cfg_t  cfg,
    input  logic                 accept,
    input  logic                 req_type,
    input  logic [7:0]           rx_byte,
    input  logic [7:0]           read_index,
    output logic                 rslt_valid,
    output sfrc_pkg::sfrc_rslt_t rslt
);
    import sfrc_pkg::*;

    sfrc_mode_t        mode_reg, mode_next;
    logic              esc_reg, esc_next;
    logic [7:0]        cmd_reg, cmd_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [15:0]       crc_reg, crc_next;
    logic [7:0]        last1_reg, last1_next;
    logic [7:0]        last2_reg, last2_next;

    logic [7:0]        mem [BUF_DEPTH];
    logic [7:0]        mem_q_reg;

    logic              a_valid_reg;
    logic              a_ended_reg, a_ended_next;
    logic              a_ok_reg, a_ok_next;
    logic [7:0]        a_cmd_reg;
    logic [7:0]        a_cnt_reg, a_cnt_next;
    logic              a_hit_reg, a_hit_next;

    logic              is_rx;
    logic              is_start;
    logic              is_finish;
    logic              is_escape;
    logic [7:0]        literal;
    logic              mem_wr;
    logic [CMP_W-1:0]  idx_ext;
    logic [CMP_W-1:0]  cnt_ext;
    logic [CNT_W-1:0]  cnt_less2;

    assign is_rx     = (req_type == REQ_RX);
    assign is_start  = (rx_byte == cfg.start_byte);
    assign is_finish = (rx_byte == cfg.finish_byte) && !esc_reg;
    assign is_escape = (rx_byte == cfg.escape_byte) && !esc_reg;
    assign literal   = esc_reg ? ~rx_byte : rx_byte;
    assign idx_ext   = {{(CMP_W-8){1'b0}}, read_index};
    assign cnt_ext   = CMP_W'(cnt_reg);
    assign cnt_less2 = cnt_reg - CNT_W'(2);

    always_comb
    begin
        mode_next    = mode_reg;
        esc_next     = esc_reg;
        cmd_next     = cmd_reg;
        cnt_next     = cnt_reg;
        crc_next     = crc_reg;
        last1_next   = last1_reg;
        last2_next   = last2_reg;
        mem_wr       = 1'b0;
        a_ended_next = 1'b0;
        a_ok_next    = 1'b0;
        a_cnt_next   = 8'h00;
        a_hit_next   = 1'b0;

        if (!is_rx)
        begin
            a_hit_next = (idx_ext < cnt_ext) && (idx_ext < CMP_W'(BUF_DEPTH));
        end
        else if (is_start)
        begin
            mode_next = MODE_CMD;
            esc_next  = 1'b0;
            cnt_next  = '0;
            crc_next  = CRC_INIT;
        end
        else if (mode_reg == MODE_IDLE)
        begin
            mode_next = MODE_IDLE;
        end
        else if (is_finish)
        begin
            a_ended_next = 1'b1;
            if ((mode_reg == MODE_DATA) && (cnt_reg >= CNT_W'(2))
                && (crc_reg == {last1_reg, last2_reg}))
            begin
                a_ok_next  = 1'b1;
                cnt_next   = cnt_less2;
                a_cnt_next = (CMP_W'(cnt_less2) > CMP_W'(255)) ? 8'hFF : 8'(cnt_less2);
            end
            mode_next = MODE_IDLE;
        end
        else if (is_escape)
        begin
            esc_next = 1'b1;
        end
        else
        begin
            esc_next = 1'b0;
            if (mode_reg == MODE_CMD)
            begin
                cmd_next  = literal;
                mode_next = MODE_DATA;
                cnt_next  = '0;
                crc_next  = crc_feed(CRC_INIT, literal);
            end
            else if (cnt_reg < CNT_W'(BUF_DEPTH))
            begin
                if (cnt_reg >= CNT_W'(2))
                begin
                    crc_next = crc_feed(crc_reg, last2_reg);
                end
                mem_wr     = 1'b1;
                last2_next = last1_reg;
                last1_next = literal;
                cnt_next   = cnt_reg + CNT_W'(1);
            end
            else
            begin
                mode_next = MODE_IDLE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_IDLE;
            esc_reg     <= 1'b0;
            cmd_reg     <= 8'h00;
            cnt_reg     <= '0;
            crc_reg     <= CRC_INIT;
            a_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= accept;
            if (accept)
            begin
                mode_reg <= mode_next;
                esc_reg  <= esc_next;
                cmd_reg  <= cmd_next;
                cnt_reg  <= cnt_next;
                crc_reg  <= crc_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            last1_reg   <= last1_next;
            last2_reg   <= last2_next;
            a_ended_reg <= a_ended_next;
            a_ok_reg    <= a_ok_next;
            a_cmd_reg   <= cmd_next;
            a_cnt_reg   <= a_cnt_next;
            a_hit_reg   <= a_hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && mem_wr)
        begin
            mem[cnt_reg[BUF_AW-1:0]] <= literal;
        end
        if (accept && !is_rx)
        begin
            mem_q_reg <= mem[BUF_AW'(read_index)];
        end
    end

    assign rslt_valid         = a_valid_reg;
    assign rslt.frame_ended   = a_ended_reg;
    assign rslt.frame_ok      = a_ok_reg;
    assign rslt.cmd_value     = a_cmd_reg;
    assign rslt.payload_count = a_cnt_reg;
    assign rslt.read_data     = a_hit_reg ? mem_q_reg : 8'h00;

endmodule

[rtl/sfrc_outq.sv]
// Three-entry output queue that holds finished results while the consumer stalls.
module sfrc_outq (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  sfrc_pkg::sfrc_rslt_t push_data,
    input  logic                 pop,
    output logic                 head_valid,
    output sfrc_pkg::sfrc_rslt_t head_data,
    output logic [1:0]           level
);
    import sfrc_pkg::*;

    sfrc_rslt_t  q_reg [OQ_DEPTH];
    logic [1:0]  wr_ptr_reg, wr_ptr_next;
    logic [1:0]  rd_ptr_reg, rd_ptr_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        do_pop;

    assign do_pop     = pop && (cnt_reg != 2'd0);
    assign wr_ptr_next = (wr_ptr_reg == 2'(OQ_DEPTH - 1)) ? 2'd0 : wr_ptr_reg + 2'd1;
    assign rd_ptr_next = (rd_ptr_reg == 2'(OQ_DEPTH - 1)) ? 2'd0 : rd_ptr_reg + 2'd1;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !do_pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (!push && do_pop)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head_valid = (cnt_reg != 2'd0);
    assign head_data  = q_reg[rd_ptr_reg];
    assign level      = cnt_reg;

endmodule

[rtl/stuffed_frame_receiver_crc16_top.sv]
// Top level of the byte-stuffed frame receiver with CRC-16/MODBUS check.
// An accepted item passes through the result register and the output queue before it is shown.
// Throughput: one item per cycle while in_stall is low; framing and CRC update each accepted byte.
// The input stalls when three results are held between the result register and the output queue.
// Reset clears the receiver state, the CRC to FFFF and the delimiters to FE, FD and A5.
// The payload buffer is not cleared; only bytes written since the last start are read.
module stuffed_frame_receiver_crc16_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        req_type,
    input  logic [7:0]                  rx_byte,
    input  logic [7:0]                  read_index,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        frame_ended,
    output logic                        frame_ok,
    output logic [7:0]                  cmd_value,
    output logic [7:0]                  payload_count,
    output logic [7:0]                  read_data,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [sfrc_pkg::APB_AW-1:0] paddr,
    input  logic [sfrc_pkg::APB_DW-1:0] pwdata,
    output logic [sfrc_pkg::APB_DW-1:0] prdata,
    output logic                        pready
);
    import sfrc_pkg::*;

    sfrc_cfg_t   cfg;
    sfrc_rslt_t  rslt;
    sfrc_rslt_t  head;
    logic        rslt_valid;
    logic        accept;
    logic [1:0]  q_level;
    logic [2:0]  in_flight;

    assign in_flight = {1'b0, q_level} + {2'b00, rslt_valid};
    assign in_stall  = (in_flight >= 3'(OQ_DEPTH));
    assign accept    = in_valid && !in_stall;

    sfrc_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sfrc_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .accept     (accept),
        .req_type   (req_type),
        .rx_byte    (rx_byte),
        .read_index (read_index),
        .rslt_valid (rslt_valid),
        .rslt       (rslt)
    );

    sfrc_outq u_outq (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (rslt_valid),
        .push_data  (rslt),
        .pop        (!out_stall),
        .head_valid (out_valid),
        .head_data  (head),
        .level      (q_level)
    );

    assign frame_ended   = head.frame_ended;
    assign frame_ok      = head.frame_ok;
    assign cmd_value     = head.cmd_value;
    assign payload_count = head.payload_count;
    assign read_data     = head.read_data;

endmodule

[rtl/sfrc_checker.sv]
// Port-level checker for the frame receiver and its bind to the top level.
module sfrc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic       frame_ended,
    input logic       frame_ok,
    input logic [7:0] payload_count,
    input logic [7:0] read_data
);

    a_ok_needs_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_ok |-> frame_ended)
        else $error("A good frame was reported without a frame end.");

    a_count_needs_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (payload_count != 8'h00) |-> frame_ok)
        else $error("A payload count was reported for a frame that did not pass.");

    a_read_is_alone: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (read_data != 8'h00) |-> !frame_ended && (payload_count == 8'h00))
        else $error("Read data appeared on a frame result.");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("A stalled result was dropped.");

endmodule

bind stuffed_frame_receiver_crc16_top sfrc_checker u_sfrc_checker (.*);

[test/stuffed_frame_receiver_crc16_top_test.sv]
// Self-checking testbench for the byte-stuffed frame receiver with CRC-16/MODBUS check.
module stuffed_frame_receiver_crc16_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import sfrc_pkg::*;

    logic                clk;
    logic                rst_n      = 1'b0;
    logic                in_valid   = 1'b0;
    logic                in_stall;
    logic                req_type   = REQ_RX;
    logic [7:0]          rx_byte    = 8'h00;
    logic [7:0]          read_index = 8'h00;
    logic                out_valid;
    logic                out_stall  = 1'b0;
    logic                frame_ended;
    logic                frame_ok;
    logic [7:0]          cmd_value;
    logic [7:0]          payload_count;
    logic [7:0]          read_data;
    logic                psel       = 1'b0;
    logic                penable    = 1'b0;
    logic                pwrite     = 1'b0;
    logic [APB_AW-1:0]   paddr      = '0;
    logic [APB_DW-1:0]   pwdata     = '0;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    logic [7:0]          cfg_start  = START_RESET;
    logic [7:0]          cfg_escape = ESCAPE_RESET;
    logic [7:0]          cfg_finish = FINISH_RESET;

    sfrc_mode_t          rx_state   = MODE_IDLE;
    logic                escape_armed = 1'b0;
    logic [7:0]          command_byte = 8'h00;
    int unsigned         fill_count = 0;
    logic [7:0]          payload_bytes [BUF_DEPTH];
    logic [15:0]         crc_acc    = CRC_INIT;

    sfrc_rslt_t          pending_results [$];
    int                  mismatches    = 0;
    int                  items_sent    = 0;
    int                  hold_requests = 0;
    bit                  calm          = 1'b0;

    stuffed_frame_receiver_crc16_top u_dut (.*);

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial begin
        foreach (payload_bytes[i]) payload_bytes[i] = 8'h00;
    end

    function automatic logic [15:0] crc_step(input logic [15:0] acc, input logic [7:0] data);
        logic [15:0] c;
        logic        fb;
        c = acc;
        for (int k = 0; k < 8; k++) begin
            fb = c[0] ^ data[k];
            c = c >> 1;
            if (fb)
                c = c ^ CRC_POLY;
        end
        return c;
    endfunction

    function automatic sfrc_rslt_t frame_predict(input logic req, input logic [7:0] byte_in,
                                                 input logic [7:0] idx);
        sfrc_rslt_t  r;
        logic [7:0]  b;
        logic [15:0] got;
        r = '0;
        b = byte_in;
        if (req == REQ_READ) begin
            if (idx < fill_count && idx < BUF_DEPTH)
                r.read_data = payload_bytes[idx];
        end else if (b == cfg_start) begin
            rx_state     = MODE_CMD;
            escape_armed = 1'b0;
            fill_count   = 0;
            crc_acc      = CRC_INIT;
        end else if (rx_state == MODE_IDLE) begin
        end else if (b == cfg_finish && !escape_armed) begin
            r.frame_ended = 1'b1;
            if (rx_state == MODE_DATA && fill_count >= 2 && fill_count <= BUF_DEPTH) begin
                got = {payload_bytes[8'(fill_count - 1)], payload_bytes[8'(fill_count - 2)]};
                if (crc_acc == got) begin
                    fill_count      = fill_count - 2;
                    r.frame_ok      = 1'b1;
                    r.payload_count = (fill_count > 255) ? 8'hFF : fill_count[7:0];
                end
            end
            rx_state = MODE_IDLE;
        end else if (b == cfg_escape && !escape_armed) begin
            escape_armed = 1'b1;
        end else begin
            if (escape_armed) begin
                b = ~b;
                escape_armed = 1'b0;
            end
            if (rx_state == MODE_CMD) begin
                command_byte = b;
                rx_state     = MODE_DATA;
                fill_count   = 0;
                crc_acc      = crc_step(CRC_INIT, b);
            end else if (fill_count < BUF_DEPTH) begin
                if (fill_count >= 2)
                    crc_acc = crc_step(crc_acc, payload_bytes[8'(fill_count - 2)]);
                payload_bytes[8'(fill_count)] = b;
                fill_count++;
            end else begin
                rx_state = MODE_IDLE;
            end
        end
        r.cmd_value = command_byte;
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want) begin
            $display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    task automatic check_result();
        sfrc_rslt_t want;
        if (pending_results.size() == 0) begin
            $display("%0t ns: unexpected result, expected none, got %0h %0h %0h %0h %0h", $time,
                     frame_ended, frame_ok, cmd_value, payload_count, read_data);
            mismatches++;
        end else begin
            want = pending_results.pop_front();
            compare_field("frame_ended", {7'd0, want.frame_ended}, {7'd0, frame_ended});
            compare_field("frame_ok", {7'd0, want.frame_ok}, {7'd0, frame_ok});
            compare_field("cmd_value", want.cmd_value, cmd_value);
            compare_field("payload_count", want.payload_count, payload_count);
            compare_field("read_data", want.read_data, read_data);
        end
    endtask

    initial begin : result_sink
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        forever begin
            @(posedge clk);
            if (out_valid && !out_stall)
                check_result();
            if (hold_seen != hold_requests) begin
                hold_seen = hold_requests;
                hold_left = 80;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else begin
                out_stall <= !calm && ($urandom_range(99) < 7);
            end
        end
    end

    task automatic send_item(input logic req, input logic [7:0] b, input logic [7:0] idx);
        if (!calm && $urandom_range(99) < 7) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid   <= 1'b1;
        req_type   <= req;
        rx_byte    <= b;
        read_index <= idx;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_results.push_back(frame_predict(req, b, idx));
        items_sent++;
    endtask

    task automatic send_raw(input logic [7:0] b);
        send_item(REQ_RX, b, 8'($urandom));
    endtask

    task automatic send_read(input logic [7:0] idx);
        send_item(REQ_READ, 8'($urandom), idx);
    endtask

    task automatic send_literal(input logic [7:0] b);
        logic [7:0] inv;
        inv = ~b;
        if (b == cfg_start || b == cfg_finish || b == cfg_escape ||
            (inv != cfg_start && $urandom_range(99) < 5)) begin
            send_raw(cfg_escape);
            send_raw(inv);
        end else begin
            send_raw(b);
        end
    endtask

    task automatic send_frame(input logic [7:0] cmd, input logic [7:0] body[$],
                              input logic [15:0] crc_flip, input bit with_crc, input bit close);
        logic [15:0] crc;
        crc = crc_step(CRC_INIT, cmd);
        foreach (body[i]) crc = crc_step(crc, body[i]);
        crc = crc ^ crc_flip;
        send_raw(cfg_start);
        send_literal(cmd);
        foreach (body[i]) send_literal(body[i]);
        if (with_crc) begin
            send_literal(crc[7:0]);
            send_literal(crc[15:8]);
        end
        if (close)
            send_raw(cfg_finish);
    endtask

    task automatic send_random_frame();
        logic [7:0] body[$];
        int         len;
        int         pick;
        pick = $urandom_range(99);
        if (pick < 88)
            len = $urandom_range(0, 12);
        else if (pick < 99)
            len = $urandom_range(13, 60);
        else
            len = $urandom_range(240, 256);
        repeat (len) body.push_back(8'($urandom));
        pick = $urandom_range(99);
        if (pick < 5) begin
            send_raw(cfg_start);
            send_raw(cfg_finish);
        end else if (pick < 80) begin
            send_frame(8'($urandom), body, 16'h0000, 1'b1, 1'b1);
        end else if (pick < 90) begin
            send_frame(8'($urandom), body, 16'h0001 << $urandom_range(15), 1'b1, 1'b1);
        end else if (pick < 95) begin
            send_frame(8'($urandom), body, 16'h0000, 1'b0, 1'b1);
        end else begin
            send_frame(8'($urandom), body, 16'h0000, 1'b1, 1'b0);
        end
        repeat ($urandom_range(0, 2)) send_read(8'($urandom_range(0, len + 2)));
    endtask

    task automatic send_random_episode();
        int pick;
        pick = $urandom_range(99);
        if (pick < 75)
            send_random_frame();
        else if (pick < 90)
            repeat ($urandom_range(1, 6)) send_raw(8'($urandom));
        else
            repeat ($urandom_range(1, 3)) send_read(8'($urandom));
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic apb_write(input logic [1:0] reg_idx, input logic [7:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= {24'h000000, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        case (reg_idx)
            REG_START:  cfg_start  = value;
            REG_ESCAPE: cfg_escape = value;
            REG_FINISH: cfg_finish = value;
            default: ;
        endcase
    endtask

    task automatic write_delimiters(input logic [7:0] s, input logic [7:0] e, input logic [7:0] f);
        settle();
        apb_write(REG_START, s);
        apb_write(REG_ESCAPE, e);
        apb_write(REG_FINISH, f);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic test_directed();
        logic [7:0] body[$];
        send_read(8'hFF);
        send_raw(ESCAPE_RESET);
        send_raw(FINISH_RESET);
        send_raw(START_RESET);
        send_raw(FINISH_RESET);
        send_raw(START_RESET);
        send_raw(ESCAPE_RESET);
        send_raw(START_RESET);
        body = {8'h00, 8'hFE, 8'hA5, 8'hFD};
        send_frame(8'hFF, body, 16'h0000, 1'b1, 1'b1);
        send_read(8'h00);
        send_read(8'h03);
        send_read(8'h04);
        body = {8'h11};
        send_frame(8'h00, body, 16'h0000, 1'b0, 1'b1);
        body = {};
        send_frame(8'h5A, body, 16'h8000, 1'b1, 1'b1);
        send_read(8'h01);
    endtask

    task automatic test_delimiter_settings();
        write_delimiters(8'h00, 8'hFF, 8'h80);
        repeat (30) send_random_episode();
        // Start and finish share a value, so the start byte always wins.
        write_delimiters(8'hFF, 8'h00, 8'hFF);
        repeat (20) send_random_episode();
        // Escape and finish share a value, so that byte always closes the frame.
        write_delimiters(8'h7E, 8'h7D, 8'h7D);
        repeat (20) send_random_episode();
        write_delimiters(START_RESET, ESCAPE_RESET, FINISH_RESET);
    endtask

    task automatic test_backpressure();
        logic [7:0] body[$];
        repeat (24) body.push_back(8'($urandom));
        calm = 1'b1;
        hold_requests++;
        send_frame(8'($urandom), body, 16'h0000, 1'b1, 1'b1);
        repeat (6) send_read(8'($urandom_range(0, 26)));
        calm = 1'b0;
    endtask

    task automatic test_overflow();
        logic [7:0] body[$];
        repeat (254) body.push_back(8'($urandom));
        send_frame(8'($urandom), body, 16'h0000, 1'b1, 1'b1);
        send_read(8'd253);
        send_read(8'd254);
        repeat (2) body.push_back(8'($urandom));
        send_frame(8'($urandom), body, 16'h0000, 1'b0, 1'b0);
        send_literal(8'($urandom));
        send_raw(cfg_finish);
        send_read(8'hFF);
    endtask

    task automatic test_calm_stream();
        calm = 1'b1;
        repeat (25) send_random_episode();
        calm = 1'b0;
    endtask

    task automatic test_random_traffic();
        while (items_sent < 1350)
            send_random_episode();
    endtask

    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_delimiter_settings();
        test_backpressure();
        test_overflow();
        test_calm_stream();
        test_random_traffic();
        settle();
        if (mismatches == 0)
            $display("stuffed_frame_receiver_crc16_top_test OK");
        else
            $display("stuffed_frame_receiver_crc16_top_test NOT OK");
        $finish;
    end

    initial begin
        #1_000_000;
        $display("stuffed_frame_receiver_crc16_top_test NOT OK");
        $finish;
    end

endmodule
